>>> rtl/abqc_pkg.sv
// abqc_pkg: shared constants, command and result types for the audio buffer queue controller
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps

package abqc_pkg;

    localparam int QUEUE_DEPTH    = 32;
    localparam int RELEASED_DEPTH = 32;
    localparam int FETCH_MAX      = 32;
    localparam int CMDQ_DEPTH     = 2;

    localparam int TAG_W    = 64;
    localparam int COUNT_W  = 20;
    localparam int KIND_W   = 3;
    localparam int MAXC_W   = 6;
    localparam int LAYOUT_W = 2;
    localparam int TOTAL_W  = 32;

    localparam int PQ_IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int PQ_FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int RQ_IDX_W   = $clog2(RELEASED_DEPTH);
    localparam int RQ_FILL_W  = $clog2(RELEASED_DEPTH + 1);
    localparam int FETCH_W    = $clog2(FETCH_MAX + 1);
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_QUEUE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PLAY  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STOP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FLUSH = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FETCH = 3'd5;

    localparam logic [LAYOUT_W-1:0] LAYOUT_MONO     = 2'd0;
    localparam logic [LAYOUT_W-1:0] LAYOUT_STEREO   = 2'd1;
    localparam logic [LAYOUT_W-1:0] LAYOUT_SURROUND = 2'd2;

    // divide by three through a reciprocal: exact for inputs below 2**19
    localparam int                HALF_W     = COUNT_W - 1;
    localparam int                DIV3_SHIFT = 20;
    localparam logic [HALF_W-1:0] DIV3_MULT  = 19'd349526;

    typedef enum logic [2:0] {
        CMD_QUEUE,
        CMD_PLAY,
        CMD_STOP,
        CMD_FLUSH,
        CMD_TICK,
        CMD_FETCH,
        CMD_NOP
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t             op;
        logic [TAG_W-1:0]    tag;
        logic [COUNT_W-1:0]  count;
        logic [MAXC_W-1:0]   fetch_limit;
    } cmd_t;

    typedef struct packed {
        logic                accepted;
        logic                flush_found;
        logic                started;
        logic [TAG_W-1:0]    started_tag;
        logic                released_event;
        logic                sink_flush;
        logic                release_overflow;
        logic                tag_valid;
        logic [TAG_W-1:0]    tag_out;
        logic                last;
        logic [TOTAL_W-1:0]  played_total;
    } result_t;

endpackage

>>> rtl/abqc_if.sv
// abqc_req_if / abqc_rsp_if: valid/ready channels for command words and result words
// depends on abqc_pkg for field widths
`timescale 1ns / 1ps

interface abqc_req_if;
    logic                          valid;
    logic                          ready;
    logic [abqc_pkg::KIND_W-1:0]   kind;
    logic [abqc_pkg::TAG_W-1:0]    buffer_tag;
    logic [abqc_pkg::COUNT_W-1:0]  sample_count;
    logic [abqc_pkg::MAXC_W-1:0]   fetch_limit;

    modport source (output valid, kind, buffer_tag, sample_count, fetch_limit, input ready);
    modport sink   (input valid, kind, buffer_tag, sample_count, fetch_limit, output ready);
endinterface

interface abqc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          accepted;
    logic                          flush_found;
    logic                          started;
    logic [abqc_pkg::TAG_W-1:0]    started_tag;
    logic                          released_event;
    logic                          sink_flush;
    logic                          release_overflow;
    logic                          tag_valid;
    logic [abqc_pkg::TAG_W-1:0]    tag_out;
    logic                          last;
    logic [abqc_pkg::TOTAL_W-1:0]  played_total;

    modport source (output valid, accepted, flush_found, started, started_tag, released_event,
                    sink_flush, release_overflow, tag_valid, tag_out, last, played_total,
                    input ready);
    modport sink   (input valid, accepted, flush_found, started, started_tag, released_event,
                    sink_flush, release_overflow, tag_valid, tag_out, last, played_total,
                    output ready);
endinterface

>>> rtl/abqc_front.sv
// abqc_front: accepts request words, decodes the kind and holds one command word
// depends on abqc_pkg and abqc_if
`timescale 1ns / 1ps

module abqc_front (
    input  logic            clk,
    input  logic            rst_n,
    abqc_req_if.sink        req,
    output abqc_pkg::cmd_t  push_cmd,
    output logic            push_valid,
    input  logic            push_ready
);
    import abqc_pkg::*;

    cmd_t    cmd_reg;
    logic    valid_reg;
    cmd_op_t op_dec;
    logic    take;

    always_comb
    begin
        unique case (req.kind)
            KIND_QUEUE: op_dec = CMD_QUEUE;
            KIND_PLAY:  op_dec = CMD_PLAY;
            KIND_STOP:  op_dec = CMD_STOP;
            KIND_FLUSH: op_dec = CMD_FLUSH;
            KIND_TICK:  op_dec = CMD_TICK;
            KIND_FETCH: op_dec = CMD_FETCH;
            default:    op_dec = CMD_NOP;
        endcase
    end

    assign req.ready  = !valid_reg || push_ready;
    assign take       = req.valid && req.ready;
    assign push_valid = valid_reg;
    assign push_cmd   = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cmd_reg   <= '0;
        end
        else
        begin
            if (take)
            begin
                valid_reg           <= 1'b1;
                cmd_reg.op          <= op_dec;
                cmd_reg.tag         <= req.buffer_tag;
                cmd_reg.count       <= req.sample_count;
                cmd_reg.fetch_limit <= req.fetch_limit;
            end
            else if (push_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/abqc_cmd_fifo.sv
// abqc_cmd_fifo: short command queue between the decode front and the execution back
// depends on abqc_pkg
`timescale 1ns / 1ps

module abqc_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  abqc_pkg::cmd_t  push_cmd,
    input  logic            push_valid,
    output logic            push_ready,
    output abqc_pkg::cmd_t  pop_cmd,
    output logic            pop_valid,
    input  logic            pop_ready
);
    import abqc_pkg::*;

    cmd_t                   slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0]  wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0]  rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0]  cnt_reg;
    logic                   do_push;
    logic                   do_pop;
    logic [CMDQ_PTR_W-1:0]  wr_ptr_next;
    logic [CMDQ_PTR_W-1:0]  rd_ptr_next;

    assign push_ready = (cnt_reg != CMDQ_CNT_W'(CMDQ_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    assign wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/abqc_back.sv
// abqc_back: execution sequencer with pending and released tag memories and result register
// depends on abqc_pkg and abqc_if
`timescale 1ns / 1ps

module abqc_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [abqc_pkg::LAYOUT_W-1:0]   cfg_wdata,
    input  abqc_pkg::cmd_t                  cmd,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    abqc_rsp_if.source                      rsp
);
    import abqc_pkg::*;

    localparam int LIM_W = (FETCH_W > RQ_FILL_W) ? FETCH_W : RQ_FILL_W;
    localparam int PROD_W = 2 * HALF_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_START,
        S_LOAD,
        S_DIV,
        S_FREAD,
        S_FDATA,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [COUNT_W-1:0]  count;
    } pq_entry_t;

    state_t                 state_reg;
    cmd_t                   cmd_reg;
    logic [LAYOUT_W-1:0]    layout_reg;
    logic                   playing_reg;
    logic                   active_valid_reg;
    logic [TAG_W-1:0]       active_tag_reg;
    logic [COUNT_W-1:0]     frames_left_reg;
    logic [PQ_IDX_W-1:0]    pq_head_reg;
    logic [PQ_FILL_W-1:0]   pq_fill_reg;
    logic [RQ_IDX_W-1:0]    rq_head_reg;
    logic [RQ_FILL_W-1:0]   rq_fill_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic [LIM_W-1:0]       fetch_left_reg;
    logic [COUNT_W-1:0]     cnt_reg;
    logic [PROD_W-1:0]      prod_reg;
    result_t                row_reg;
    result_t                out_reg;
    logic                   out_valid_reg;

    pq_entry_t              pq_mem [QUEUE_DEPTH];
    logic [TAG_W-1:0]       rq_mem [RELEASED_DEPTH];
    pq_entry_t              pq_rdata_reg;
    logic [TAG_W-1:0]       rq_rdata_reg;

    logic                   out_free;
    logic                   emit_fire;
    logic                   pq_full;
    logic                   rq_full;
    logic [PQ_FILL_W:0]     pq_sum;
    logic [PQ_IDX_W-1:0]    pq_slot;
    logic [PQ_IDX_W-1:0]    pq_head_inc;
    logic [RQ_FILL_W:0]     rq_sum;
    logic [RQ_IDX_W-1:0]    rq_slot;
    logic [RQ_IDX_W-1:0]    rq_head_inc;
    logic                   pq_we;
    logic                   pq_re;
    logic                   rq_we;
    logic                   rq_re;
    logic                   start_pop;
    logic                   tick_release;
    logic [MAXC_W-1:0]      max_clamped;
    logic [LIM_W-1:0]       fetch_cap;
    logic [LIM_W-1:0]       fetch_lim;
    logic [HALF_W-1:0]      load_half;
    logic [COUNT_W-1:0]     frames_calc;
    result_t                emit_row;
    result_t                idle_row;
    result_t                fetch_row;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign emit_fire = (state_reg == S_EMIT) && out_free;
    assign cmd_ready = (state_reg == S_IDLE);
    assign pq_full   = (pq_fill_reg == PQ_FILL_W'(QUEUE_DEPTH));
    assign rq_full   = (rq_fill_reg == RQ_FILL_W'(RELEASED_DEPTH));

    // ring slot arithmetic, correct for any depth
    always_comb
    begin
        pq_sum = (PQ_FILL_W + 1)'(pq_head_reg) + (PQ_FILL_W + 1)'(pq_fill_reg);
        if (pq_sum >= (PQ_FILL_W + 1)'(QUEUE_DEPTH))
        begin
            pq_sum = pq_sum - (PQ_FILL_W + 1)'(QUEUE_DEPTH);
        end
        pq_slot = PQ_IDX_W'(pq_sum);
        rq_sum = (RQ_FILL_W + 1)'(rq_head_reg) + (RQ_FILL_W + 1)'(rq_fill_reg);
        if (rq_sum >= (RQ_FILL_W + 1)'(RELEASED_DEPTH))
        begin
            rq_sum = rq_sum - (RQ_FILL_W + 1)'(RELEASED_DEPTH);
        end
        rq_slot = RQ_IDX_W'(rq_sum);
    end

    assign pq_head_inc = (pq_head_reg == PQ_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : pq_head_reg + 1'b1;
    assign rq_head_inc = (rq_head_reg == RQ_IDX_W'(RELEASED_DEPTH - 1)) ? '0 : rq_head_reg + 1'b1;

    assign start_pop    = playing_reg && (pq_fill_reg != '0) && !active_valid_reg;
    assign tick_release = active_valid_reg && (frames_left_reg <= COUNT_W'(1));

    assign pq_we = (state_reg == S_EXEC) && (cmd_reg.op == CMD_QUEUE) && !pq_full;
    assign pq_re = (state_reg == S_START) && start_pop;
    assign rq_we = (state_reg == S_EXEC) && (cmd_reg.op == CMD_TICK) && tick_release && !rq_full;
    assign rq_re = (state_reg == S_FREAD);

    // fetch count: min(fetch_limit, FETCH_MAX, released fill)
    assign max_clamped = (cmd_reg.fetch_limit > MAXC_W'(FETCH_MAX)) ? MAXC_W'(FETCH_MAX)
                                                                     : cmd_reg.fetch_limit;
    assign fetch_cap   = LIM_W'(max_clamped);
    assign fetch_lim   = (fetch_cap > LIM_W'(rq_fill_reg)) ? LIM_W'(rq_fill_reg) : fetch_cap;

    assign load_half = pq_rdata_reg.count[COUNT_W-1:1];

    always_comb
    begin
        unique case (layout_reg)
            LAYOUT_STEREO:   frames_calc = {1'b0, cnt_reg[COUNT_W-1:1]};
            LAYOUT_SURROUND: frames_calc = COUNT_W'(prod_reg >> DIV3_SHIFT);
            default:         frames_calc = cnt_reg;
        endcase
    end

    always_comb
    begin
        emit_row              = row_reg;
        emit_row.played_total = total_reg;
        idle_row              = '0;
        idle_row.last         = 1'b1;
        fetch_row             = '0;
        fetch_row.tag_valid   = 1'b1;
        fetch_row.tag_out     = rq_rdata_reg;
        fetch_row.last        = (fetch_left_reg == '0);
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.accepted         = out_reg.accepted;
    assign rsp.flush_found      = out_reg.flush_found;
    assign rsp.started          = out_reg.started;
    assign rsp.started_tag      = out_reg.started_tag;
    assign rsp.released_event   = out_reg.released_event;
    assign rsp.sink_flush       = out_reg.sink_flush;
    assign rsp.release_overflow = out_reg.release_overflow;
    assign rsp.tag_valid        = out_reg.tag_valid;
    assign rsp.tag_out          = out_reg.tag_out;
    assign rsp.last             = out_reg.last;
    assign rsp.played_total     = out_reg.played_total;

    always_ff @(posedge clk)
    begin
        if (pq_we)
        begin
            pq_mem[pq_slot] <= '{tag: cmd_reg.tag, count: cmd_reg.count};
        end
        if (pq_re)
        begin
            pq_rdata_reg <= pq_mem[pq_head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rq_we)
        begin
            rq_mem[rq_slot] <= active_tag_reg;
        end
        if (rq_re)
        begin
            rq_rdata_reg <= rq_mem[rq_head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cmd_reg          <= '0;
            layout_reg       <= LAYOUT_STEREO;
            playing_reg      <= 1'b0;
            active_valid_reg <= 1'b0;
            active_tag_reg   <= '0;
            frames_left_reg  <= '0;
            pq_head_reg      <= '0;
            pq_fill_reg      <= '0;
            rq_head_reg      <= '0;
            rq_fill_reg      <= '0;
            total_reg        <= '0;
            fetch_left_reg   <= '0;
            cnt_reg          <= '0;
            prod_reg         <= '0;
            row_reg          <= '0;
            out_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                layout_reg <= cfg_wdata;
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg   <= cmd;
                        row_reg   <= idle_row;
                        state_reg <= S_EXEC;
                    end
                end

                S_EXEC:
                begin
                    unique case (cmd_reg.op)
                        CMD_QUEUE:
                        begin
                            if (pq_full)
                            begin
                                state_reg <= S_EMIT;
                            end
                            else
                            begin
                                pq_fill_reg      <= pq_fill_reg + 1'b1;
                                row_reg.accepted <= 1'b1;
                                state_reg        <= S_START;
                            end
                        end
                        CMD_PLAY:
                        begin
                            playing_reg <= 1'b1;
                            state_reg   <= S_START;
                        end
                        CMD_STOP:
                        begin
                            playing_reg <= 1'b0;
                            state_reg   <= S_EMIT;
                        end
                        CMD_FLUSH:
                        begin
                            row_reg.flush_found <= (pq_fill_reg != '0);
                            pq_fill_reg         <= '0;
                            state_reg           <= S_EMIT;
                        end
                        CMD_TICK:
                        begin
                            if (tick_release)
                            begin
                                frames_left_reg        <= '0;
                                active_valid_reg       <= 1'b0;
                                active_tag_reg         <= '0;
                                row_reg.released_event <= 1'b1;
                                if (rq_full)
                                begin
                                    row_reg.release_overflow <= 1'b1;
                                end
                                else
                                begin
                                    rq_fill_reg <= rq_fill_reg + 1'b1;
                                end
                                state_reg <= S_START;
                            end
                            else
                            begin
                                if (active_valid_reg)
                                begin
                                    frames_left_reg <= frames_left_reg - 1'b1;
                                end
                                state_reg <= S_EMIT;
                            end
                        end
                        CMD_FETCH:
                        begin
                            if (fetch_lim == '0)
                            begin
                                state_reg <= S_EMIT;
                            end
                            else
                            begin
                                fetch_left_reg <= fetch_lim;
                                state_reg      <= S_FREAD;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_EMIT;
                        end
                    endcase
                end

                S_START:
                begin
                    if (!playing_reg || (pq_fill_reg == '0))
                    begin
                        row_reg.sink_flush <= !active_valid_reg || !playing_reg;
                        state_reg          <= S_EMIT;
                    end
                    else if (active_valid_reg)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        pq_head_reg <= pq_head_inc;
                        pq_fill_reg <= pq_fill_reg - 1'b1;
                        state_reg   <= S_LOAD;
                    end
                end

                S_LOAD:
                begin
                    active_valid_reg    <= 1'b1;
                    active_tag_reg      <= pq_rdata_reg.tag;
                    row_reg.started     <= 1'b1;
                    row_reg.started_tag <= pq_rdata_reg.tag;
                    total_reg           <= total_reg + TOTAL_W'(pq_rdata_reg.count);
                    cnt_reg             <= pq_rdata_reg.count;
                    prod_reg            <= PROD_W'(load_half) * PROD_W'(DIV3_MULT);
                    state_reg           <= S_DIV;
                end

                S_DIV:
                begin
                    frames_left_reg <= frames_calc;
                    state_reg       <= S_EMIT;
                end

                S_FREAD:
                begin
                    rq_head_reg    <= rq_head_inc;
                    rq_fill_reg    <= rq_fill_reg - 1'b1;
                    fetch_left_reg <= fetch_left_reg - 1'b1;
                    state_reg      <= S_FDATA;
                end

                S_FDATA:
                begin
                    row_reg   <= fetch_row;
                    state_reg <= S_EMIT;
                end

                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_reg <= emit_row;
                        if (row_reg.tag_valid && !row_reg.last)
                        begin
                            state_reg <= S_FREAD;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/audio_buffer_queue_controller.sv
// audio_buffer_queue_controller: top level joining decode front, command queue and back end
// depends on abqc_pkg, abqc_if, abqc_front, abqc_cmd_fifo, abqc_back
//
//   port        dir   handshake            word
//   req         in    valid / ready        kind, buffer_tag, sample_count, fetch_limit
//   rsp         out   valid / ready        one result word, last marks end of a command
//   cfg_we      in    write enable         channel_layout in cfg_wdata
//
// back end per word: stop, flush, plain tick, refused queue, unused kind go EXEC, EMIT;
// queue, play or releasing tick go EXEC, START, then LOAD, DIV if a buffer starts, EMIT;
// fetch of n tags goes EXEC, then FREAD, FDATA, EMIT per tag, or EXEC, EMIT for none
// a req word passes the front register and command queue; memory reads are registered
// front and command queue keep taking words while a result waits on rsp, until they fill
// memories need no clearing after reset; state and counters reset asynchronously
`timescale 1ns / 1ps

module audio_buffer_queue_controller (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [abqc_pkg::LAYOUT_W-1:0]   cfg_wdata,
    abqc_req_if.sink                        req,
    abqc_rsp_if.source                      rsp
);
    import abqc_pkg::*;

    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;
    cmd_t queue_cmd;
    logic queue_valid;
    logic queue_ready;

    abqc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_cmd   (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready)
    );

    abqc_cmd_fifo u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_cmd    (queue_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    abqc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd        (queue_cmd),
        .cmd_valid  (queue_valid),
        .cmd_ready  (queue_ready),
        .rsp        (rsp)
    );

endmodule

>>> rtl/abqc_checker.sv
// abqc_checker: port-level assertions on result words of the top level, bound below
// depends on abqc_pkg; attaches to audio_buffer_queue_controller
`timescale 1ns / 1ps

module abqc_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rsp_valid,
    input  logic                           rsp_ready,
    input  logic                           accepted,
    input  logic                           flush_found,
    input  logic                           started,
    input  logic                           released_event,
    input  logic                           sink_flush,
    input  logic                           release_overflow,
    input  logic                           tag_valid,
    input  logic [abqc_pkg::TAG_W-1:0]     tag_out,
    input  logic                           last,
    input  logic [abqc_pkg::TOTAL_W-1:0]   played_total
);
    import abqc_pkg::*;

    // stalled word holds its tag_out, last and played_total
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(tag_out) && $stable(last)
                                    && $stable(played_total))
        else $error("result word changed while stalled");

    // only fetch words come in runs
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !tag_valid |-> last)
        else $error("non-fetch result without last");

    // a started buffer never reports a sink flush, a found flush or a fetched tag
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && started |-> !sink_flush && !tag_valid && !flush_found)
        else $error("start flagged with conflicting fields");

    // overflow only comes with a release, never with a queue accept
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && release_overflow |-> released_event && !accepted)
        else $error("overflow without release");

endmodule

bind audio_buffer_queue_controller abqc_checker u_abqc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .accepted         (rsp.accepted),
    .flush_found      (rsp.flush_found),
    .started          (rsp.started),
    .released_event   (rsp.released_event),
    .sink_flush       (rsp.sink_flush),
    .release_overflow (rsp.release_overflow),
    .tag_valid        (rsp.tag_valid),
    .tag_out          (rsp.tag_out),
    .last             (rsp.last),
    .played_total     (rsp.played_total)
);

>>> tb/tb_audio_buffer_queue_controller.sv
// tb_audio_buffer_queue_controller: self-checking bench for the audio buffer queue controller
// drives command words on req, predicts every result word and checks each one arriving on rsp
// depends on abqc_pkg, abqc_if and rtl/audio_buffer_queue_controller.sv
`timescale 1ns / 1ps

module tb_audio_buffer_queue_controller;
    import abqc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_WORDS  = 45;
    localparam int MAX_PRINTS    = 40;

    localparam logic [KIND_W-1:0]   KIND_UNUSED_6 = 3'd6;
    localparam logic [KIND_W-1:0]   KIND_UNUSED_7 = 3'd7;
    localparam logic [LAYOUT_W-1:0] LAYOUT_SPARE  = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [LAYOUT_W-1:0] cfg_wdata;

    abqc_req_if req_ch ();
    abqc_rsp_if rsp_ch ();

    audio_buffer_queue_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predicted block state
    logic [LAYOUT_W-1:0] exp_layout;
    logic [TAG_W-1:0]    pend_tag   [QUEUE_DEPTH];
    logic [COUNT_W-1:0]  pend_count [QUEUE_DEPTH];
    logic [PQ_IDX_W-1:0] pend_head;
    int unsigned         pend_fill;
    bit                  is_playing;
    bit                  buf_active;
    logic [TAG_W-1:0]    buf_tag;
    logic [COUNT_W-1:0]  buf_frames;
    logic [TAG_W-1:0]    done_tag   [RELEASED_DEPTH];
    logic [RQ_IDX_W-1:0] done_head;
    int unsigned         done_fill;
    logic [TOTAL_W-1:0]  samples_started;
    result_t             expected_words [$];

    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned words_sent = 0;
    int unsigned words_checked = 0;
    int unsigned starts_seen = 0;
    int unsigned releases_seen = 0;
    int unsigned drops_seen = 0;
    int unsigned refusals_seen = 0;

    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned stall_len = 0;
    int unsigned stall_seq = 0;
    bit          stim_running = 1'b0;

    function automatic int unsigned channels_of(logic [LAYOUT_W-1:0] lay);
        case (lay)
            LAYOUT_STEREO:   return 2;
            LAYOUT_SURROUND: return 6;
            default:         return 1;
        endcase
    endfunction

    function automatic logic [TAG_W-1:0] rand_tag();
        return {$urandom, $urandom};
    endfunction

    task automatic expect_word(result_t r);
        expected_words.insert(expected_words.size(), r);
    endtask

    task automatic try_begin_buffer(inout result_t r);
        int unsigned cnt;
        if (!is_playing || pend_fill == 0)
        begin
            if (!buf_active || !is_playing)
                r.sink_flush = 1'b1;
        end
        else if (!buf_active)
        begin
            cnt             = 32'(pend_count[pend_head]);
            buf_tag         = pend_tag[pend_head];
            pend_head       = PQ_IDX_W'((32'(pend_head) + 1) % QUEUE_DEPTH);
            pend_fill--;
            buf_active      = 1'b1;
            buf_frames      = COUNT_W'(cnt / channels_of(exp_layout));
            samples_started = samples_started + TOTAL_W'(cnt);
            r.started       = 1'b1;
            r.started_tag   = buf_tag;
            starts_seen++;
        end
    endtask

    task automatic predict_words(logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag,
                                 logic [COUNT_W-1:0] cnt, logic [MAXC_W-1:0] maxc);
        result_t             r;
        int unsigned         n;
        int unsigned         k;
        logic [PQ_IDX_W-1:0] pslot;
        logic [RQ_IDX_W-1:0] rslot;
        r = '0;
        if (kind == KIND_FETCH)
        begin
            n = 32'(maxc);
            if (n > FETCH_MAX)
                n = FETCH_MAX;
            if (n > done_fill)
                n = done_fill;
            if (n == 0)
            begin
                r.last         = 1'b1;
                r.played_total = samples_started;
                expect_word(r);
            end
            for (k = 0; k < n; k++)
            begin
                r              = '0;
                r.tag_valid    = 1'b1;
                r.tag_out      = done_tag[done_head];
                done_head      = RQ_IDX_W'((32'(done_head) + 1) % RELEASED_DEPTH);
                done_fill--;
                r.last         = (k + 1 == n);
                r.played_total = samples_started;
                expect_word(r);
            end
        end
        else
        begin
            case (kind)
                KIND_QUEUE:
                begin
                    if (pend_fill < QUEUE_DEPTH)
                    begin
                        pslot             = PQ_IDX_W'((32'(pend_head) + pend_fill) % QUEUE_DEPTH);
                        pend_tag[pslot]   = tag;
                        pend_count[pslot] = cnt;
                        pend_fill++;
                        r.accepted = 1'b1;
                        try_begin_buffer(r);
                    end
                    else
                        refusals_seen++;
                end
                KIND_PLAY:
                begin
                    is_playing = 1'b1;
                    try_begin_buffer(r);
                end
                KIND_STOP:
                    is_playing = 1'b0;
                KIND_FLUSH:
                begin
                    r.flush_found = (pend_fill != 0);
                    pend_fill     = 0;
                end
                KIND_TICK:
                begin
                    if (buf_active)
                    begin
                        if (buf_frames <= COUNT_W'(1))
                        begin
                            buf_frames = '0;
                            if (done_fill < RELEASED_DEPTH)
                            begin
                                rslot = RQ_IDX_W'((32'(done_head) + done_fill) % RELEASED_DEPTH);
                                done_tag[rslot] = buf_tag;
                                done_fill++;
                            end
                            else
                            begin
                                r.release_overflow = 1'b1;
                                drops_seen++;
                            end
                            buf_active       = 1'b0;
                            buf_tag          = '0;
                            r.released_event = 1'b1;
                            releases_seen++;
                            try_begin_buffer(r);
                        end
                        else
                            buf_frames--;
                    end
                end
                default: ;
            endcase
            r.last         = 1'b1;
            r.played_total = samples_started;
            expect_word(r);
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (fail_count < MAX_PRINTS)
            $display("mismatch at result word %0d: %s got %h expected %h",
                     words_checked, what, got, want);
        fail_count++;
    endtask

    task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic check_result_word();
        result_t want;
        if (expected_words.size() == 0)
            report_mismatch("word with nothing expected, tag_out", rsp_ch.tag_out, '0);
        else
        begin
            want = expected_words.pop_front();
            check_field("accepted", 64'(rsp_ch.accepted), 64'(want.accepted));
            check_field("flush_found", 64'(rsp_ch.flush_found), 64'(want.flush_found));
            check_field("started", 64'(rsp_ch.started), 64'(want.started));
            check_field("started_tag", rsp_ch.started_tag, want.started_tag);
            check_field("released_event", 64'(rsp_ch.released_event),
                        64'(want.released_event));
            check_field("sink_flush", 64'(rsp_ch.sink_flush), 64'(want.sink_flush));
            check_field("release_overflow", 64'(rsp_ch.release_overflow),
                        64'(want.release_overflow));
            check_field("tag_valid", 64'(rsp_ch.tag_valid), 64'(want.tag_valid));
            check_field("tag_out", rsp_ch.tag_out, want.tag_out);
            check_field("last", 64'(rsp_ch.last), 64'(want.last));
            check_field("played_total", 64'(rsp_ch.played_total), 64'(want.played_total));
        end
        words_checked++;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, expected_words.size());
            $display("simulation failed");
            $finish;
        end
        else if (rst_n)
        begin
            if (cfg_we)
                exp_layout = cfg_wdata;
            if (req_ch.valid && req_ch.ready)
                predict_words(req_ch.kind, req_ch.buffer_tag, req_ch.sample_count,
                              req_ch.fetch_limit);
            if (rsp_ch.valid && rsp_ch.ready)
                check_result_word();
        end
    end

    // result side: random back-pressure plus long holds on request
    initial
    begin : sink_side
        int unsigned stall_left;
        int unsigned stall_seen;
        stall_left = 0;
        stall_seen = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_seq != stall_seen)
            begin
                stall_seen = stall_seq;
                stall_left = stall_len;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic send_word(logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag,
                             logic [COUNT_W-1:0] cnt, logic [MAXC_W-1:0] maxc);
        if ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= kind;
        req_ch.buffer_tag   <= tag;
        req_ch.sample_count <= cnt;
        req_ch.fetch_limit  <= maxc;
        do @(posedge clk); while (!req_ch.ready);
        if (kind == KIND_PLAY)
            stim_running = 1'b1;
        else if (kind == KIND_STOP)
            stim_running = 1'b0;
        words_sent++;
    endtask

    task automatic send_tick();
        send_word(KIND_TICK, rand_tag(), COUNT_W'($urandom), MAXC_W'($urandom));
    endtask

    task automatic wait_drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_layout(logic [LAYOUT_W-1:0] lay);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= lay;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic test_directed();
        send_word(KIND_FETCH, '0, '0, 6'd1);
        send_word(KIND_UNUSED_6, rand_tag(), COUNT_W'($urandom), MAXC_W'($urandom));
        send_word(KIND_UNUSED_7, rand_tag(), COUNT_W'($urandom), MAXC_W'($urandom));
        send_tick();
        send_word(KIND_QUEUE, '1, '1, '1);
        send_word(KIND_QUEUE, '0, '0, '0);
        send_word(KIND_FLUSH, '0, '0, '0);
        send_word(KIND_FLUSH, '0, '0, '0);
        send_word(KIND_PLAY, '0, '0, '0);
        send_word(KIND_STOP, '0, '0, '0);
        send_word(KIND_PLAY, '0, '0, '0);
        // zero-length buffer ends on the first tick
        send_word(KIND_QUEUE, rand_tag(), '0, '0);
        send_tick();
        send_word(KIND_QUEUE, rand_tag(), 20'd5, '0);
        send_word(KIND_QUEUE, rand_tag(), 20'd3, '0);
        send_tick();
        send_tick();
        // stopped: active buffer still runs out on ticks
        send_word(KIND_STOP, '0, '0, '0);
        send_tick();
        send_word(KIND_QUEUE, rand_tag(), COUNT_W'($urandom), '0);
        send_word(KIND_FLUSH, '0, '0, '0);
        send_word(KIND_PLAY, '0, '0, '0);
        send_word(KIND_FETCH, '0, '0, 6'd1);
        send_word(KIND_FETCH, '0, '0, '1);
        send_word(KIND_FETCH, '0, '0, '0);
    endtask

    task automatic test_fill_and_overflow();
        send_word(KIND_STOP, '0, '0, '0);
        stall_len = 300;
        stall_seq++;
        repeat (QUEUE_DEPTH + 2)
            send_word(KIND_QUEUE, rand_tag(), COUNT_W'($urandom_range(0, 1)), '0);
        send_word(KIND_PLAY, '0, '0, '0);
        repeat (RELEASED_DEPTH + 1)
            send_tick();
        repeat (2)
            send_word(KIND_QUEUE, rand_tag(), COUNT_W'($urandom_range(0, 1)), '0);
        repeat (2)
            send_tick();
        send_word(KIND_FETCH, '0, '0, 6'd40);
        send_word(KIND_FETCH, '0, '0, 6'd5);
    endtask

    task automatic test_layouts();
        logic [LAYOUT_W-1:0] lays [4];
        int unsigned         c0;
        int unsigned         c1;
        int unsigned         f0;
        int unsigned         f1;
        lays[0] = LAYOUT_MONO;
        lays[1] = LAYOUT_SURROUND;
        lays[2] = LAYOUT_SPARE;
        lays[3] = LAYOUT_STEREO;
        foreach (lays[i])
        begin
            set_layout(lays[i]);
            c0 = $urandom_range(0, 14);
            c1 = $urandom_range(0, 14);
            f0 = c0 / channels_of(lays[i]);
            f1 = c1 / channels_of(lays[i]);
            send_word(KIND_QUEUE, rand_tag(), COUNT_W'(c0), '0);
            send_word(KIND_QUEUE, rand_tag(), COUNT_W'(c1), '0);
            repeat ((f0 > 1 ? f0 : 1) + (f1 > 1 ? f1 : 1) + 1)
                send_tick();
            send_word(KIND_FETCH, '0, '0, '1);
        end
    endtask

    task automatic test_random(int unsigned count);
        int unsigned pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                // long buffers only go in while stopped and are flushed straight away
                if (!stim_running && $urandom_range(3) == 0)
                begin
                    send_word(KIND_QUEUE, rand_tag(), COUNT_W'($urandom), MAXC_W'($urandom));
                    send_word(KIND_FLUSH, rand_tag(), COUNT_W'($urandom), MAXC_W'($urandom));
                end
                else
                    send_word(KIND_QUEUE, rand_tag(), COUNT_W'($urandom_range(0, 16)),
                              MAXC_W'($urandom));
            end
            else if (pick < 65)
                send_tick();
            else if (pick < 73)
                send_word(KIND_PLAY, rand_tag(), COUNT_W'($urandom), MAXC_W'($urandom));
            else if (pick < 77)
                send_word(KIND_STOP, rand_tag(), COUNT_W'($urandom), MAXC_W'($urandom));
            else if (pick < 81)
                send_word(KIND_FLUSH, rand_tag(), COUNT_W'($urandom), MAXC_W'($urandom));
            else if (pick < 89)
                send_word(KIND_FETCH, rand_tag(), COUNT_W'($urandom),
                          MAXC_W'($urandom_range(0, 8)));
            else if (pick < 97)
                send_word(KIND_FETCH, rand_tag(), COUNT_W'($urandom), MAXC_W'($urandom));
            else
                send_word($urandom_range(1) ? KIND_UNUSED_7 : KIND_UNUSED_6, rand_tag(),
                          COUNT_W'($urandom), MAXC_W'($urandom));
        end
    endtask

    task automatic test_long_buffer();
        set_layout(LAYOUT_SURROUND);
        send_word(KIND_STOP, '0, '0, '0);
        send_word(KIND_FLUSH, '0, '0, '0);
        repeat (20)
            send_tick();
        send_word(KIND_FETCH, '0, '0, '1);
        send_word(KIND_PLAY, '0, '0, '0);
        send_word(KIND_QUEUE, rand_tag(), '1, '0);
        repeat (3)
            send_tick();
        send_word(KIND_QUEUE, rand_tag(), COUNT_W'($urandom), '0);
        send_word(KIND_FLUSH, '0, '0, '0);
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.kind         <= '0;
        req_ch.buffer_tag   <= '0;
        req_ch.sample_count <= '0;
        req_ch.fetch_limit  <= '0;
        exp_layout      = LAYOUT_STEREO;
        pend_head       = '0;
        pend_fill       = 0;
        is_playing      = 1'b0;
        buf_active      = 1'b0;
        buf_tag         = '0;
        buf_frames      = '0;
        done_head       = '0;
        done_fill       = 0;
        samples_started = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct  = 15;
        sink_idle_pct = 86;
        test_directed();

        wait_drain();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_fill_and_overflow();

        src_idle_pct  = 86;
        sink_idle_pct = 15;
        test_layouts();

        set_layout(LAYOUT_MONO);
        src_idle_pct  = 15;
        sink_idle_pct = 86;
        test_random(RANDOM_WORDS);
        set_layout(LAYOUT_SPARE);
        src_idle_pct  = 86;
        sink_idle_pct = 15;
        test_random(RANDOM_WORDS);
        set_layout(2'($urandom_range(0, 3)));
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random(RANDOM_WORDS);

        test_long_buffer();
        wait_drain();

        $display("covered %0d command words and %0d result words across channel layouts 0 to 3",
                 words_sent, words_checked);
        $display("buffers started %0d, released %0d, dropped on full release queue %0d, %s %0d",
                 starts_seen, releases_seen, drops_seen, "refused on full queue", refusals_seen);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/abqc_pkg.sv
rtl/abqc_if.sv
rtl/abqc_front.sv
rtl/abqc_cmd_fifo.sv
rtl/abqc_back.sv
rtl/audio_buffer_queue_controller.sv
rtl/abqc_checker.sv
tb/tb_audio_buffer_queue_controller.sv
